/* design/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// Command frame deframer package
// Phase encoding, status codes and the result record shared by the deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_IGNORE  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADSTART = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic [7:0]  command;
        logic [15:0] length;
        t_status     status;
    } t_result;

endpackage

/* design/command_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Command frame deframer
// Parses marker, command, length, payload and XOR checksum from a byte stream.
// ----------------------------------------------------------------------------
// A byte is captured in the input register and its result is presented from
// the result register. One byte per cycle while the output is not stalled;
// the parse step between the input register and the result register is combinational.
// Reset: synchronous, active low; the parser awaits the start marker and the
// start marker register returns to 0x02.
module command_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,      // start_marker
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // rx_byte
    input  logic        i_s_axis_tlast,  // buffer_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // payload_byte [7:0], command_code [15:8], frame_length [31:16],
    // frame_status [33:32], zero fill [39:34]
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser   // result_kind
);
    import cfd_pkg::*;

    logic [7:0] r_start_marker;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_step;
    logic       w_emit;
    t_result    w_result;
    logic       w_in_req;

    assign o_cfg_ready     = 1'b1;
    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_in_req        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= 8'h02;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start_marker <= i_cfg_data;
            end
            if (w_in_req) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= w_emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_req) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    cfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_marker (r_start_marker),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {6'b000000, r_out.status, r_out.length,
                              r_out.command, r_out.payload};

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !w_step)
        else $error("parser advanced over a result still waiting");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_in_byte))
        else $error("pending input byte lost before it was parsed");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_start_marker == $past(i_cfg_data))
        else $error("start marker write not taken");
`endif

endmodule

/* design/cfd_parser.sv */
// ----------------------------------------------------------------------------
// Command frame deframer parser
// Frame state machine that turns one byte per step into at most one result.
// ----------------------------------------------------------------------------
module cfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [7:0]        i_marker,
    output logic              o_emit,
    output cfd_pkg::t_result  o_result
);
    import cfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_xor, n_xor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_cmd   <= 8'h00;
            r_len   <= 16'h0000;
            r_seen  <= 16'h0000;
            r_xor   <= 8'h00;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_xor   <= n_xor;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_cmd            = r_cmd;
        n_len            = r_len;
        n_seen           = r_seen;
        n_xor            = r_xor;
        o_emit           = 1'b0;
        o_result.kind    = KIND_PAYLOAD;
        o_result.payload = 8'h00;
        o_result.status  = ST_OK;
        case (r_phase)
            PH_START: begin
                n_cmd  = 8'h00;
                n_len  = 16'h0000;
                n_seen = 16'h0000;
                if (i_byte != i_marker) begin
                    n_xor           = 8'h00;
                    o_emit          = 1'b1;
                    o_result.kind   = KIND_STATUS;
                    o_result.status = ST_BADSTART;
                    n_phase         = PH_IGNORE;
                end else begin
                    n_xor   = i_byte;
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'h00};
                n_xor   = r_xor ^ i_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = r_len | {8'h00, i_byte};
                n_xor   = r_xor ^ i_byte;
                n_phase = (n_len == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_xor  = r_xor ^ i_byte;
                n_seen = 16'(r_seen + 16'd1);
                if (!i_last) begin
                    o_emit           = 1'b1;
                    o_result.payload = i_byte;
                end
                n_phase = (n_seen == r_len) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_CHECK: begin
                o_emit          = 1'b1;
                o_result.kind   = KIND_STATUS;
                o_result.status = (i_byte == r_xor) ? ST_OK : ST_MISMATCH;
                n_phase         = PH_IGNORE;
            end
            PH_IGNORE: begin
                n_phase = PH_IGNORE;
            end
            default: begin
                n_phase = PH_IGNORE;
            end
        endcase
        if (i_last) begin
            if (!o_emit && r_phase != PH_IGNORE && n_phase != PH_IGNORE) begin
                o_emit           = 1'b1;
                o_result.kind    = KIND_STATUS;
                o_result.payload = 8'h00;
                o_result.status  = ST_TRUNC;
            end
            n_phase = PH_START;
        end
        o_result.command = n_cmd;
        o_result.length  = n_len;
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_phase == PH_START)
        else $error("buffer end did not return the parser to the start phase");

    a_ignore_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IGNORE |-> !o_emit)
        else $error("result produced while ignoring trailing bytes");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_seen < r_len)
        else $error("payload count reached the declared length inside the payload");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && o_result.kind == KIND_PAYLOAD |->
            r_phase == PH_PAYLOAD && o_result.status == ST_OK)
        else $error("payload result outside the payload phase");
`endif

endmodule
